/* design/aac_rtp_interleaved_packetizer_macros.svh */
// ----------------------------------------------------------------------------
// AAC RTP packetizer assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AAC_RTP_INTERLEAVED_PACKETIZER_MACROS_SVH
`define AAC_RTP_INTERLEAVED_PACKETIZER_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset
`define AAC_PK_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included
`define AAC_PK_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AAC_PK_ASSERT(name, clk, rstn, prop, msg)
`define AAC_PK_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* design/aac_pk_pkg.sv */
// ----------------------------------------------------------------------------
// AAC RTP packetizer package
// Payload types, microcode format, program ROM and header constants.
// ----------------------------------------------------------------------------
package aac_pk_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [12:0] frame_len;
        logic [31:0] stamp_ms;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_start;
        logic       packet_last;
    } out_item_t;

    localparam int unsigned HEADER_BYTES = 20;

    // Header byte values
    localparam logic [7:0]  HDR_DOLLAR  = 8'h24;
    localparam logic [7:0]  HDR_RTP_V2  = 8'h80;
    localparam logic [7:0]  HDR_AU_HI   = 8'h00;
    localparam logic [7:0]  HDR_AU_LO   = 8'h10;
    localparam logic [15:0] LEN_ADJUST  = 16'd16;

    // sample_rate / 1000 by reciprocal: exact for every 17-bit rate
    localparam logic [17:0] RATE_RECIP  = 18'd134218;
    localparam int unsigned RATE_SHIFT  = 27;

    // Configuration register indexes
    localparam logic [2:0] REG_MTU_SIZE    = 3'd0;
    localparam logic [2:0] REG_SAMPLE_RATE = 3'd1;
    localparam logic [2:0] REG_SSRC        = 3'd2;
    localparam logic [2:0] REG_PAYLOAD_TYP = 3'd3;
    localparam logic [2:0] REG_CHANNEL     = 3'd4;
    localparam logic [2:0] REG_CYCLE_MS    = 3'd5;
    localparam logic [2:0] REG_INIT_SEQ    = 3'd6;

    // Microcode
    localparam int unsigned STEP_W = 5;
    localparam int unsigned HSEL_W = 5;

    localparam logic [STEP_W-1:0] STEP_FETCH = 5'd0;
    localparam logic [STEP_W-1:0] STEP_OPEN  = 5'd1;
    localparam logic [STEP_W-1:0] STEP_DIVW  = 5'd2;
    localparam logic [STEP_W-1:0] STEP_MUL   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_FRAG  = 5'd4;
    localparam logic [STEP_W-1:0] STEP_HDR0  = 5'd5;
    localparam logic [STEP_W-1:0] STEP_HDRN  = 5'd24;
    localparam logic [STEP_W-1:0] STEP_DATA  = 5'd25;

    // Header byte positions
    localparam logic [HSEL_W-1:0] HB_DOLLAR  = 5'd0;
    localparam logic [HSEL_W-1:0] HB_CHANNEL = 5'd1;
    localparam logic [HSEL_W-1:0] HB_LEN_HI  = 5'd2;
    localparam logic [HSEL_W-1:0] HB_LEN_LO  = 5'd3;
    localparam logic [HSEL_W-1:0] HB_RTP_V2  = 5'd4;
    localparam logic [HSEL_W-1:0] HB_MARK_PT = 5'd5;
    localparam logic [HSEL_W-1:0] HB_SEQ_HI  = 5'd6;
    localparam logic [HSEL_W-1:0] HB_SEQ_LO  = 5'd7;
    localparam logic [HSEL_W-1:0] HB_TS_3    = 5'd8;
    localparam logic [HSEL_W-1:0] HB_TS_2    = 5'd9;
    localparam logic [HSEL_W-1:0] HB_TS_1    = 5'd10;
    localparam logic [HSEL_W-1:0] HB_TS_0    = 5'd11;
    localparam logic [HSEL_W-1:0] HB_SSRC_3  = 5'd12;
    localparam logic [HSEL_W-1:0] HB_SSRC_2  = 5'd13;
    localparam logic [HSEL_W-1:0] HB_SSRC_1  = 5'd14;
    localparam logic [HSEL_W-1:0] HB_SSRC_0  = 5'd15;
    localparam logic [HSEL_W-1:0] HB_AU_HI   = 5'd16;
    localparam logic [HSEL_W-1:0] HB_AU_LO   = 5'd17;
    localparam logic [HSEL_W-1:0] HB_FLEN_HI = 5'd18;
    localparam logic [HSEL_W-1:0] HB_FLEN_LO = 5'd19;

    typedef enum logic [2:0] {
        ACT_FETCH,
        ACT_DIV_START,
        ACT_DIV_WAIT,
        ACT_TS_MUL,
        ACT_FRAG,
        ACT_HDR,
        ACT_DATA
    } act_t;

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_JUMP,
        COND_DIV_BUSY,
        COND_DISPATCH
    } cond_t;

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [HSEL_W-1:0] hsel;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic accept;
        logic frame_open;
        logic frag_open;
        logic flen_zero;
        logic div_busy;
        logic out_free;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        w = '{act: ACT_FETCH, cond: COND_JUMP, hsel: '0, target: STEP_FETCH};
        case (step) inside
            STEP_FETCH: w = '{act: ACT_FETCH, cond: COND_DISPATCH, hsel: '0,
                              target: STEP_FETCH};
            STEP_OPEN:  w = '{act: ACT_DIV_START, cond: COND_NEXT, hsel: '0,
                              target: STEP_FETCH};
            STEP_DIVW:  w = '{act: ACT_DIV_WAIT, cond: COND_DIV_BUSY, hsel: '0,
                              target: STEP_DIVW};
            STEP_MUL:   w = '{act: ACT_TS_MUL, cond: COND_NEXT, hsel: '0,
                              target: STEP_FETCH};
            STEP_FRAG:  w = '{act: ACT_FRAG, cond: COND_NEXT, hsel: '0,
                              target: STEP_FETCH};
            [STEP_HDR0:STEP_HDRN]:
                        w = '{act: ACT_HDR, cond: COND_NEXT,
                              hsel: HSEL_W'(step - STEP_HDR0), target: STEP_FETCH};
            STEP_DATA:  w = '{act: ACT_DATA, cond: COND_JUMP, hsel: '0,
                              target: STEP_FETCH};
            default:    w = '{act: ACT_FETCH, cond: COND_JUMP, hsel: '0,
                              target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* design/aac_rtp_interleaved_packetizer.sv */
// ----------------------------------------------------------------------------
// AAC RTP interleaved packetizer
// Cuts AAC frames into RTP packets framed for RTSP interleaved transport.
// ----------------------------------------------------------------------------
// Frame bytes enter on s_valid/s_ready/s_data, one per transaction; frame_len
// and stamp_ms are taken on a frame's first byte. Packet bytes leave on
// m_valid/m_ready/m_data, one per transaction, flagged on '$' and on the last
// byte of each packet. The user must write the registers through cfg_valid,
// cfg_ready, cfg_index and cfg_data only while the block is idle (not enforced).
// Within an open fragment a byte that is taken shows on m_data the next cycle,
// so the stream runs at one byte per cycle while m_ready stays high. A frame's
// first byte is held while the sequencer starts the serial remainder unit for
// the timestamp, waits on it, does one multiply and the fragment setup, and
// sends the 20 header bytes; then the held data byte leaves. A byte opening a
// later fragment goes through setup and the 20 header bytes before it leaves.
// Header bytes leave one per cycle from the microcoded sequencer, barring stalls.
// Reset restores register defaults, closes any frame and empties the output.
// With m_valid high and m_ready low the byte holds and emitting steps stall.
// ----------------------------------------------------------------------------
`include "aac_rtp_interleaved_packetizer_macros.svh"

module aac_rtp_interleaved_packetizer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  aac_pk_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output aac_pk_pkg::out_item_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    // configuration
    logic [10:0] mtu_reg;
    logic [16:0] rate_reg;
    logic [31:0] ssrc_reg;
    logic [6:0]  pt_reg;
    logic [7:0]  chan_reg;
    logic [31:0] cycle_reg;

    // packet state
    logic [15:0] seq_reg, seq_next;
    logic [12:0] frame_rem_reg, frame_rem_next;
    logic [10:0] frag_rem_reg, frag_rem_next;
    logic [12:0] flen_reg;
    logic [31:0] ts_reg;
    logic [31:0] stamp_reg;
    logic [7:0]  pend_reg;
    logic [10:0] frag_len_reg;
    logic        mark_reg;
    logic [7:0]  rate_q_reg;
    logic        out_valid_reg, out_valid_next;
    aac_pk_pkg::out_item_t out_data_reg, out_data_next;

    aac_pk_pkg::ucode_t      ctrl;
    aac_pk_pkg::seq_status_t st;

    logic        cfg_fire;
    logic        out_free;
    logic        accept;
    logic        frame_open;
    logic        frag_open;
    logic        open_frame;
    logic        hdr_fire;
    logic        data_fire;
    logic [7:0]  data_src;
    logic [7:0]  hdr_byte;
    logic [15:0] pkt_len;
    logic [10:0] cap;
    logic [10:0] frag_calc;
    logic        mark_calc;
    logic [34:0] rate_prod;
    logic [39:0] ts_prod;
    logic        div_busy;
    logic [31:0] div_rem;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || m_ready;
    assign s_ready    = (ctrl.act == aac_pk_pkg::ACT_FETCH) && out_free;
    assign accept     = s_valid && s_ready;
    assign frame_open = (frame_rem_reg != '0);
    assign frag_open  = (frag_rem_reg != '0);
    assign open_frame = accept && !frame_open && (s_data.frame_len != '0);
    assign hdr_fire   = (ctrl.act == aac_pk_pkg::ACT_HDR) && out_free;
    assign data_fire  = ((ctrl.act == aac_pk_pkg::ACT_DATA) && out_free) ||
                        (accept && frame_open && frag_open);
    assign data_src   = (ctrl.act == aac_pk_pkg::ACT_DATA) ? pend_reg : s_data.data_byte;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

    assign st = '{accept: accept, frame_open: frame_open, frag_open: frag_open,
                  flen_zero: (s_data.frame_len == '0), div_busy: div_busy,
                  out_free: out_free};

    aac_pk_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .ctrl    (ctrl)
    );

    aac_pk_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ctrl.act == aac_pk_pkg::ACT_DIV_START),
        .dividend  (stamp_reg),
        .divisor   (cycle_reg),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    assign rate_prod = 35'(rate_reg) * 35'(aac_pk_pkg::RATE_RECIP);
    assign ts_prod   = 40'(rate_q_reg) * 40'(div_rem);

    // fragment payload limit and marker
    assign cap       = (mtu_reg > 11'(aac_pk_pkg::HEADER_BYTES))
                     ? mtu_reg - 11'(aac_pk_pkg::HEADER_BYTES) : 11'd1;
    assign frag_calc = (frame_rem_reg < {2'b00, cap}) ? frame_rem_reg[10:0] : cap;
    assign mark_calc = (frame_rem_reg <= {2'b00, cap});
    assign pkt_len   = 16'(frag_len_reg) + aac_pk_pkg::LEN_ADJUST;

    always_comb begin
        case (ctrl.hsel)
            aac_pk_pkg::HB_DOLLAR:  hdr_byte = aac_pk_pkg::HDR_DOLLAR;
            aac_pk_pkg::HB_CHANNEL: hdr_byte = chan_reg;
            aac_pk_pkg::HB_LEN_HI:  hdr_byte = pkt_len[15:8];
            aac_pk_pkg::HB_LEN_LO:  hdr_byte = pkt_len[7:0];
            aac_pk_pkg::HB_RTP_V2:  hdr_byte = aac_pk_pkg::HDR_RTP_V2;
            aac_pk_pkg::HB_MARK_PT: hdr_byte = {mark_reg, pt_reg};
            aac_pk_pkg::HB_SEQ_HI:  hdr_byte = seq_reg[15:8];
            aac_pk_pkg::HB_SEQ_LO:  hdr_byte = seq_reg[7:0];
            aac_pk_pkg::HB_TS_3:    hdr_byte = ts_reg[31:24];
            aac_pk_pkg::HB_TS_2:    hdr_byte = ts_reg[23:16];
            aac_pk_pkg::HB_TS_1:    hdr_byte = ts_reg[15:8];
            aac_pk_pkg::HB_TS_0:    hdr_byte = ts_reg[7:0];
            aac_pk_pkg::HB_SSRC_3:  hdr_byte = ssrc_reg[31:24];
            aac_pk_pkg::HB_SSRC_2:  hdr_byte = ssrc_reg[23:16];
            aac_pk_pkg::HB_SSRC_1:  hdr_byte = ssrc_reg[15:8];
            aac_pk_pkg::HB_SSRC_0:  hdr_byte = ssrc_reg[7:0];
            aac_pk_pkg::HB_AU_HI:   hdr_byte = aac_pk_pkg::HDR_AU_HI;
            aac_pk_pkg::HB_AU_LO:   hdr_byte = aac_pk_pkg::HDR_AU_LO;
            aac_pk_pkg::HB_FLEN_HI: hdr_byte = flen_reg[12:5];
            aac_pk_pkg::HB_FLEN_LO: hdr_byte = {flen_reg[4:0], 3'b000};
            default:                hdr_byte = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (hdr_fire) begin
            out_valid_next = 1'b1;
            out_data_next  = '{out_byte: hdr_byte,
                               packet_start: (ctrl.hsel == aac_pk_pkg::HB_DOLLAR),
                               packet_last: 1'b0};
        end else if (data_fire) begin
            out_valid_next = 1'b1;
            out_data_next  = '{out_byte: data_src, packet_start: 1'b0,
                               packet_last: (frag_rem_reg == 11'd1)};
        end

        frame_rem_next = frame_rem_reg;
        if (open_frame) begin
            frame_rem_next = s_data.frame_len;
        end else if (data_fire) begin
            frame_rem_next = frame_rem_reg - 13'd1;
        end

        frag_rem_next = frag_rem_reg;
        if (ctrl.act == aac_pk_pkg::ACT_FRAG) begin
            frag_rem_next = frag_calc;
        end else if (data_fire) begin
            frag_rem_next = frag_rem_reg - 11'd1;
        end

        seq_next = seq_reg;
        if (cfg_fire && (cfg_index == aac_pk_pkg::REG_INIT_SEQ)) begin
            seq_next = cfg_data[15:0];
        end else if (hdr_fire && (ctrl.hsel == aac_pk_pkg::HB_FLEN_LO)) begin
            // advance once the header of this packet is out
            seq_next = seq_reg + 16'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mtu_reg       <= 11'd1400;
            rate_reg      <= 17'd44100;
            ssrc_reg      <= '0;
            pt_reg        <= 7'd97;
            chan_reg      <= '0;
            cycle_reg     <= 32'hFFFF_FFFF;
            seq_reg       <= '0;
            frame_rem_reg <= '0;
            frag_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                case (cfg_index)
                    aac_pk_pkg::REG_MTU_SIZE:    mtu_reg      <= cfg_data[10:0];
                    aac_pk_pkg::REG_SAMPLE_RATE: rate_reg     <= cfg_data[16:0];
                    aac_pk_pkg::REG_SSRC:        ssrc_reg     <= cfg_data;
                    aac_pk_pkg::REG_PAYLOAD_TYP: pt_reg       <= cfg_data[6:0];
                    aac_pk_pkg::REG_CHANNEL:     chan_reg     <= cfg_data[7:0];
                    aac_pk_pkg::REG_CYCLE_MS:    cycle_reg    <= cfg_data;
                    default: ;
                endcase
            end
            seq_reg       <= seq_next;
            frame_rem_reg <= frame_rem_next;
            frag_rem_reg  <= frag_rem_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        if (accept) begin
            pend_reg <= s_data.data_byte;
        end
        if (open_frame) begin
            flen_reg  <= s_data.frame_len;
            stamp_reg <= s_data.stamp_ms;
        end
        if (ctrl.act == aac_pk_pkg::ACT_DIV_START) begin
            rate_q_reg <= rate_prod[34:aac_pk_pkg::RATE_SHIFT];
        end
        if (ctrl.act == aac_pk_pkg::ACT_TS_MUL) begin
            ts_reg <= ts_prod[31:0];
        end
        if (ctrl.act == aac_pk_pkg::ACT_FRAG) begin
            frag_len_reg <= frag_calc;
            mark_reg     <= mark_calc;
        end
    end

    // an open fragment always lies inside an open frame
    `AAC_PK_ASSERT(a_frag_in_frame, aclk, aresetn, (frame_rem_reg == '0) |-> (frag_rem_reg == '0), "fragment open without a frame")
    // the remainder unit runs only while the sequencer waits on it
    `AAC_PK_ASSERT(a_div_owned, aclk, aresetn, div_busy |-> (ctrl.act == aac_pk_pkg::ACT_DIV_WAIT), "remainder unit busy outside its wait step")
    // one sequence step per packet, taken after the last header byte
    `AAC_PK_ASSERT(a_seq_step, aclk, aresetn, (hdr_fire && (ctrl.hsel == aac_pk_pkg::HB_FLEN_LO) && !cfg_fire) |=> (seq_reg == $past(seq_reg) + 16'd1), "sequence number did not advance")
    // no input is taken while a header is being sent
    `AAC_PK_ASSERT_ALWAYS(a_no_accept_in_hdr, aclk, (ctrl.act == aac_pk_pkg::ACT_HDR) |-> !s_ready, "input ready during header")

endmodule

/* design/aac_pk_rem.sv */
// ----------------------------------------------------------------------------
// AAC RTP packetizer remainder unit
// Restoring 32-bit remainder, one quotient bit per cycle; divisor zero
// leaves the dividend unchanged.
// ----------------------------------------------------------------------------
module aac_pk_rem (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] num_reg;
    logic [31:0] rem_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted   = {rem_reg, num_reg[31]};
    assign diff      = shifted - {1'b0, divisor};
    assign busy      = busy_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            num_reg  <= dividend;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[30:0], 1'b0};
            // subtract when the partial remainder reaches the divisor
            rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/aac_pk_seq.sv */
// ----------------------------------------------------------------------------
// AAC RTP packetizer sequencer
// Step counter over the microcode ROM with stalls and conditional jumps.
// ----------------------------------------------------------------------------
module aac_pk_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  aac_pk_pkg::seq_status_t st,
    output aac_pk_pkg::ucode_t    ctrl
);

    logic [aac_pk_pkg::STEP_W-1:0] step_reg;
    logic [aac_pk_pkg::STEP_W-1:0] step_next;
    logic [aac_pk_pkg::STEP_W-1:0] step_inc;
    logic                          stall;

    assign ctrl     = aac_pk_pkg::ucode_rom(step_reg);
    assign step_inc = step_reg + aac_pk_pkg::STEP_W'(1);
    // hold an emitting step until the output register can take a byte
    assign stall    = ((ctrl.act == aac_pk_pkg::ACT_HDR) ||
                       (ctrl.act == aac_pk_pkg::ACT_DATA)) && !st.out_free;

    always_comb begin
        step_next = step_reg;
        if (!stall) begin
            case (ctrl.cond)
                aac_pk_pkg::COND_NEXT: step_next = step_inc;
                aac_pk_pkg::COND_JUMP: step_next = ctrl.target;
                aac_pk_pkg::COND_DIV_BUSY: step_next = st.div_busy ? ctrl.target : step_inc;
                aac_pk_pkg::COND_DISPATCH: begin
                    if (!st.accept) begin
                        step_next = step_reg;
                    end else if (!st.frame_open) begin
                        // drop a frame that claims zero length
                        step_next = st.flen_zero ? aac_pk_pkg::STEP_FETCH
                                                 : aac_pk_pkg::STEP_OPEN;
                    end else if (!st.frag_open) begin
                        step_next = aac_pk_pkg::STEP_FRAG;
                    end else begin
                        step_next = aac_pk_pkg::STEP_FETCH;
                    end
                end
                default: step_next = aac_pk_pkg::STEP_FETCH;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= aac_pk_pkg::STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule
